// ----- hw/rtl/htks_pkg.sv -----
package htks_pkg;

   localparam int COUNT_W       = 7;
   localparam int ID_W          = 6;
   localparam int HASH_W        = 64;
   localparam int BYTE_W        = 8;
   localparam int STEP_W        = 5;
   localparam int KEY_BYTES     = 24;
   localparam int WORD_BYTES    = 8;
   localparam int MOD_BITS      = 4;
   localparam int MOD_STEPS     = HASH_W / MOD_BITS;
   localparam int TOP_K_DEFAULT = 8;
   localparam int MAX_EXPERTS   = 64;
   localparam int FNV_SHIFT     = 40;

   localparam logic [HASH_W-1:0]  FNV_BASIS    = 64'hcbf29ce484222325;
   localparam logic [8:0]         FNV_PRIME_LO = 9'h1b3;
   localparam logic [COUNT_W-1:0] COUNT_RESET  = 7'd64;

   typedef enum logic [2:0] {
      HOP_HOLD,
      HOP_BASIS,
      HOP_FOLD,
      HOP_SAVE,
      HOP_RESTORE,
      HOP_MOD_STEP
   } hash_op_type;

   typedef struct packed {
      hash_op_type        op;
      logic [BYTE_W-1:0]  data_byte;
   } hash_ctrl_type;

   typedef enum logic [1:0] {
      LOP_HOLD,
      LOP_CLEAR,
      LOP_INSERT,
      LOP_POP
   } list_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREFIX,
      S_SAVE,
      S_ATTEMPT,
      S_MOD,
      S_CHECK,
      S_EMIT,
      S_ERROR
   } state_type;

endpackage

// ----- hw/rtl/hashed_top_k_expert_select_unit.sv -----
// Channel  Direction  Ports                       Contents
// req      in         req_tvalid/tready/tdata     tdata: step, layer, token
// rsp      out        rsp_tvalid/tready/tdata     tdata: expert number; tlast: is_last;
//                     rsp_tlast/tuser             tuser: bad_count
// csr      in         csr_valid/ready/data        expert pool size
//
// One item first hashes the step, layer and token bytes once, then runs each
// attempt as 8 byte folds, 16 modulo steps of 4 bits and 1 check, then emits
// the results in turn, holding while the output register is still occupied.
// All hashing and remainder steps run through the one FNV multiply and remainder unit in htks_hash.
// Reset is synchronous and clears control state; the expert list entries need none.
// A stalled result holds in the output register; req_tready rises again once
// the last result has moved into it.
module hashed_top_k_expert_select_unit #(
   parameter int TOP_K = htks_pkg::TOP_K_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [127:0]                  req_tdata,   // step, layer, token
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // expert number, zero pad
   output logic                          rsp_tlast,
   output logic                          rsp_tuser,   // bad_count
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [htks_pkg::COUNT_W-1:0]  csr_data
);
   import htks_pkg::*;

   localparam int TOTAL_W = $clog2(TOP_K + 1);

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [31:0]         attempt_ff, attempt_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [63:0]         step_ff;
   logic [31:0]         layer_ff;
   logic [31:0]         token_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_bad_ff, rsp_bad_in;

   hash_ctrl_type       hash_ctrl;
   list_op_type         list_op;
   logic [COUNT_W-1:0]  cand;
   logic                dup;
   logic [TOTAL_W-1:0]  total;
   logic [COUNT_W-1:0]  head;
   logic [191:0]        key;
   logic [63:0]         attempt_word;
   logic                req_xfer;
   logic                bad;
   logic                out_free;

   htks_hash u_hash (
      .clock (clock),
      .ctrl  (hash_ctrl),
      .count (count_ff),
      .cand  (cand)
   );

   htks_list #(
      .TOP_K   (TOP_K),
      .TOTAL_W (TOTAL_W)
   ) u_list (
      .clock (clock),
      .reset (reset),
      .op    (list_op),
      .cand  (cand),
      .dup   (dup),
      .total (total),
      .head  (head)
   );

   assign key          = {32'd0, token_ff, 32'd0, layer_ff, step_ff};
   assign attempt_word = {32'd0, attempt_ff};
   assign req_tready   = (state_ff == S_IDLE);
   assign req_xfer     = req_tvalid && req_tready;
   assign bad          = (count_ff < COUNT_W'(TOP_K)) || (count_ff > COUNT_W'(MAX_EXPERTS));
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign csr_ready    = 1'b1;

   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      attempt_in        = attempt_ff;
      hash_ctrl.op      = HOP_HOLD;
      hash_ctrl.data_byte = '0;
      list_op           = LOP_HOLD;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      rsp_id_in         = rsp_id_ff;
      rsp_last_in       = rsp_last_ff;
      rsp_bad_in        = rsp_bad_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cnt_in     = '0;
               attempt_in = '0;
               if (bad) begin
                  state_in = S_ERROR;
               end else begin
                  hash_ctrl.op = HOP_BASIS;
                  list_op      = LOP_CLEAR;
                  state_in     = S_PREFIX;
               end
            end
         end
         S_PREFIX: begin
            hash_ctrl.op        = HOP_FOLD;
            hash_ctrl.data_byte = key[{cnt_ff, 3'b000} +: BYTE_W];
            cnt_in              = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(KEY_BYTES - 1)) begin
               cnt_in   = '0;
               state_in = S_SAVE;
            end
         end
         S_SAVE: begin
            hash_ctrl.op = HOP_SAVE;
            state_in     = S_ATTEMPT;
         end
         S_ATTEMPT: begin
            hash_ctrl.op        = HOP_FOLD;
            hash_ctrl.data_byte = attempt_word[{cnt_ff[2:0], 3'b000} +: BYTE_W];
            cnt_in              = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(WORD_BYTES - 1)) begin
               cnt_in   = '0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            hash_ctrl.op = HOP_MOD_STEP;
            cnt_in       = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(MOD_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            list_op      = LOP_INSERT;
            hash_ctrl.op = HOP_RESTORE;
            attempt_in   = attempt_ff + 32'd1;
            if ((!dup && (total == TOTAL_W'(TOP_K - 1))) || (attempt_ff == '1)) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_ATTEMPT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               list_op      = LOP_POP;
               rsp_valid_in = 1'b1;
               rsp_id_in    = head[ID_W-1:0];
               rsp_last_in  = (total == TOTAL_W'(1));
               rsp_bad_in   = 1'b0;
               if (total == TOTAL_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_ERROR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = '0;
               rsp_last_in  = 1'b1;
               rsp_bad_in   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         attempt_ff   <= '0;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         attempt_ff   <= attempt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         step_ff  <= req_tdata[63:0];
         layer_ff <= req_tdata[95:64];
         token_ff <= req_tdata[127:96];
      end
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8-ID_W){1'b0}}, rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_bad_ff;

endmodule

// ----- hw/rtl/htks_hash.sv -----
module htks_hash (
   input  logic                           clock,
   input  htks_pkg::hash_ctrl_type        ctrl,
   input  logic [htks_pkg::COUNT_W-1:0]   count,
   output logic [htks_pkg::COUNT_W-1:0]   cand
);
   import htks_pkg::*;

   logic [HASH_W-1:0]  hash_ff, hash_in;
   logic [HASH_W-1:0]  prefix_ff, prefix_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [HASH_W-1:0]  mixed;
   logic [HASH_W-1:0]  product;
   logic [COUNT_W:0]   trial;
   logic [COUNT_W-1:0] rem_work;

   always_comb begin
      mixed   = hash_ff ^ {{(HASH_W-BYTE_W){1'b0}}, ctrl.data_byte};
      product = (mixed << FNV_SHIFT) + HASH_W'(mixed * FNV_PRIME_LO);

      rem_work = rem_ff;
      for (int i = 0; i < MOD_BITS; i++) begin
         trial = {rem_work, hash_ff[HASH_W-1-i]};
         if (trial >= {1'b0, count}) begin
            trial = trial - {1'b0, count};
         end
         rem_work = trial[COUNT_W-1:0];
      end

      hash_in   = hash_ff;
      prefix_in = prefix_ff;
      rem_in    = rem_ff;
      unique case (ctrl.op)
         HOP_HOLD: begin
         end
         HOP_BASIS: begin
            hash_in = FNV_BASIS;
         end
         HOP_FOLD: begin
            hash_in = product;
            rem_in  = '0;
         end
         HOP_SAVE: begin
            prefix_in = hash_ff;
         end
         HOP_RESTORE: begin
            hash_in = prefix_ff;
         end
         HOP_MOD_STEP: begin
            hash_in = hash_ff << MOD_BITS;
            rem_in  = rem_work;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      hash_ff   <= hash_in;
      prefix_ff <= prefix_in;
      rem_ff    <= rem_in;
   end

   assign cand = rem_ff;

endmodule

// ----- hw/rtl/htks_list.sv -----
module htks_list #(
   parameter int TOP_K   = htks_pkg::TOP_K_DEFAULT,
   parameter int TOTAL_W = $clog2(TOP_K + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  htks_pkg::list_op_type          op,
   input  logic [htks_pkg::COUNT_W-1:0]   cand,
   output logic                           dup,
   output logic [TOTAL_W-1:0]             total,
   output logic [htks_pkg::COUNT_W-1:0]   head
);
   import htks_pkg::*;

   logic [COUNT_W-1:0] entry_ff [TOP_K];
   logic [COUNT_W-1:0] entry_in [TOP_K];
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOP_K-1:0]   lt;
   logic               prev_lt;
   logic [COUNT_W-1:0] prev_entry;

   always_comb begin
      dup = 1'b0;
      for (int i = 0; i < TOP_K; i++) begin
         lt[i] = (TOTAL_W'(i) < total_ff) && (entry_ff[i] < cand);
         if ((TOTAL_W'(i) < total_ff) && (entry_ff[i] == cand)) begin
            dup = 1'b1;
         end
      end

      prev_lt    = 1'b1;
      prev_entry = cand;
      total_in   = total_ff;
      for (int i = 0; i < TOP_K; i++) begin
         entry_in[i] = entry_ff[i];
      end

      unique case (op)
         LOP_HOLD: begin
         end
         LOP_CLEAR: begin
            total_in = '0;
         end
         LOP_INSERT: begin
            if (!dup) begin
               for (int i = 0; i < TOP_K; i++) begin
                  if (lt[i]) begin
                     entry_in[i] = entry_ff[i];
                  end else if (prev_lt) begin
                     entry_in[i] = cand;
                  end else begin
                     entry_in[i] = prev_entry;
                  end
                  prev_lt    = lt[i];
                  prev_entry = entry_ff[i];
               end
               total_in = total_ff + TOTAL_W'(1);
            end
         end
         LOP_POP: begin
            for (int i = 0; i < TOP_K - 1; i++) begin
               entry_in[i] = entry_ff[i+1];
            end
            total_in = total_ff - TOTAL_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TOP_K; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   assign total = total_ff;
   assign head  = entry_ff[0];

endmodule
